### design/srmp_pkg.sv
package srmp_pkg;

    // Tick rate in ticks per second, and the motion limits.
    localparam int unsigned TICK_RATE      = 1000;
    localparam int unsigned POSITION_LIMIT = 20000;
    localparam int unsigned SPEED_LIMIT    = 300;
    localparam int unsigned STOP_SPEED     = 5;
    localparam int unsigned HOMING_WINDOW  = 5;

    // The constant divider takes a magnitude below 2^17. It covers
    // remainder + acceleration and remainder + velocity.
    localparam int DIV_IN_W  = 17;
    localparam int REM_W     = 16;
    localparam int MULT_W    = DIV_IN_W + 2;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_TARGET  = 2'd1,
        OP_SET_CURRENT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_MOVING   = 3'b010,
        MODE_STOPPING = 3'b100
    } mode_t;

    localparam logic [1:0] MSTATE_IDLE     = 2'd0;
    localparam logic [1:0] MSTATE_MOVING   = 2'd1;
    localparam logic [1:0] MSTATE_STOPPING = 2'd2;

    localparam logic signed [1:0] STEP_NONE = 2'sb00;
    localparam logic signed [1:0] STEP_FWD  = 2'sb01;
    localparam logic signed [1:0] STEP_REV  = 2'sb11;

endpackage

### design/srmp_cdiv.sv
module srmp_cdiv
    import srmp_pkg::*;
#(
    parameter int unsigned DIVISOR = TICK_RATE
)
(
    input  logic [DIV_IN_W-1:0] dividend,
    output logic [DIV_IN_W-1:0] quotient,
    output logic [REM_W-1:0]    remainder
);

    // Rounded-up reciprocal. With this shift the quotient is exact for every
    // dividend below 2^DIV_IN_W.
    localparam int DIV_SHIFT = DIV_IN_W + $clog2(DIVISOR);
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    // Quotient by multiplication with the reciprocal, then the remainder by
    // multiplying back with the constant divisor.
    logic [DIV_IN_W+MULT_W-1:0] prod;
    logic [DIV_IN_W+REM_W-1:0]  back;

    assign prod      = {{MULT_W{1'b0}}, dividend} * {{DIV_IN_W{1'b0}}, DIV_MULT};
    assign quotient  = DIV_IN_W'(prod >> DIV_SHIFT);
    assign back      = {{REM_W{1'b0}}, quotient} * (DIV_IN_W + REM_W)'(DIVISOR);
    assign remainder = REM_W'(dividend - DIV_IN_W'(back));

endmodule

### design/stepper_ramp_controller.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  operation, position, velocity, acceleration
// m_        out        m_valid / m_ready  accepted, motion_state, forward, step_rate,
//                                         pwm_on, step_taken, ramp_position, ramp_velocity
//
// A request is captured in the input register and its result is loaded from there
// into the output register, where m_valid marks it. One request per cycle is
// sustained while m_ready stays high. Reset (aresetn low at a clock edge) empties
// both registers and leaves the controller idle at position zero. A stalled output
// holds its result; the input side still moves in a cycle where that result is
// taken.
module stepper_ramp_controller
    import srmp_pkg::*;
#(
    parameter int unsigned TICK_RATE      = srmp_pkg::TICK_RATE,
    parameter int unsigned POSITION_LIMIT = srmp_pkg::POSITION_LIMIT,
    parameter int unsigned SPEED_LIMIT    = srmp_pkg::SPEED_LIMIT
)
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_position,
    input  logic signed [15:0] s_velocity,
    input  logic [15:0]        s_acceleration,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic [1:0]         m_motion_state,
    output logic               m_forward,
    output logic [15:0]        m_step_rate,
    output logic               m_pwm_on,
    output logic signed [1:0]  m_step_taken,
    output logic signed [31:0] m_ramp_position,
    output logic signed [15:0] m_ramp_velocity
);

    // Input register.
    logic               in_vld_reg;
    logic [1:0]         op_reg;
    logic signed [31:0] pos_reg;
    logic signed [15:0] vel_reg;
    logic [15:0]        acc_reg;

    // Controller state.
    mode_t              mode_reg, mode_next;
    logic signed [31:0] goal_pos_reg, goal_pos_next;
    logic signed [15:0] goal_vel_reg, goal_vel_next;
    logic [15:0]        goal_acc_reg, goal_acc_next;
    logic signed [31:0] now_pos_reg, now_pos_next;
    logic signed [15:0] now_vel_reg, now_vel_next;
    logic [REM_W-1:0]   vel_rem_reg, vel_rem_next;
    logic signed [REM_W:0] pos_rem_reg, pos_rem_next;
    logic signed [31:0] brake_reg, brake_next;
    logic               pulse_reg, pulse_next;

    // Output register.
    logic               m_valid_reg;
    logic               acc_ok_reg;
    logic [1:0]         mstate_reg;
    logic               fwd_reg;
    logic [15:0]        rate_reg;
    logic               pwm_reg;
    logic signed [1:0]  step_reg, step_next;
    logic signed [31:0] rpos_reg;
    logic signed [15:0] rvel_reg;

    logic fire;
    logic accepted_next;

    // Request handshake: the input register frees itself whenever its
    // request moves into the output register.
    assign fire    = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    // Distance left in the direction of travel, braking comparisons.
    logic signed [33:0] dist_raw, dist_left, brake_bias, brake_one;
    logic               has_acc, goal_ahead;

    always_comb begin
        dist_raw = 34'(goal_pos_reg) - 34'(now_pos_reg);
        if (now_vel_reg < 0 || (now_vel_reg == 0 && dist_raw < 0)) begin
            dist_left = -dist_raw;
        end else begin
            dist_left = dist_raw;
        end
        has_acc    = goal_acc_reg != '0;
        goal_ahead = goal_pos_reg > now_pos_reg;
        brake_one  = 34'(brake_reg) + 34'sd1;
        brake_bias = has_acc ? brake_one : 34'(brake_reg);
    end

    // State rule of a tick.
    mode_t              tick_mode;
    logic signed [15:0] tick_gv, tick_vel;
    logic               tick_pulse;
    logic signed [16:0] vel_abs_now;

    always_comb begin
        tick_mode   = mode_reg;
        tick_gv     = goal_vel_reg;
        tick_vel    = now_vel_reg;
        tick_pulse  = pulse_reg;
        vel_abs_now = (now_vel_reg < 0) ? -17'(now_vel_reg) : 17'(now_vel_reg);
        case (mode_reg)
            MODE_IDLE: begin
                if (now_pos_reg != goal_pos_reg) begin
                    tick_mode  = MODE_MOVING;
                    tick_pulse = 1'b1;
                    if (!has_acc) begin
                        tick_vel = goal_vel_reg;
                    end
                end
            end
            MODE_MOVING: begin
                if (brake_bias >= dist_left) begin
                    tick_gv = '0;
                    if (has_acc) begin
                        tick_mode = MODE_STOPPING;
                    end else begin
                        tick_pulse = 1'b0;
                        tick_vel   = '0;
                        tick_mode  = MODE_IDLE;
                    end
                end else begin
                    tick_gv = goal_ahead ? 16'(SPEED_LIMIT) : -16'(SPEED_LIMIT);
                end
            end
            MODE_STOPPING: begin
                if (dist_left != 0) begin
                    if (now_vel_reg != 0) begin
                        if (brake_one < dist_left) begin
                            tick_mode = MODE_MOVING;
                        end
                    end else if (dist_left <= 34'(HOMING_WINDOW)) begin
                        tick_gv = goal_ahead ? 16'(STOP_SPEED) : -16'(STOP_SPEED);
                    end else begin
                        tick_mode = MODE_IDLE;
                    end
                end else if (vel_abs_now <= 17'(STOP_SPEED)) begin
                    tick_vel   = '0;
                    tick_gv    = '0;
                    tick_mode  = MODE_IDLE;
                    tick_pulse = 1'b0;
                end
            end
            default: begin
                tick_mode = mode_reg;
            end
        endcase
    end

    // Velocity ramp: the acceleration accumulates in a remainder and the
    // whole quotient by the tick rate is the velocity change.
    logic [DIV_IN_W-1:0] vr_sum, dv_q;
    logic [REM_W-1:0]    vr_rem;
    logic signed [18:0]  vel1_w, gv1_w, dv_w, n_up, n_dn;
    logic signed [15:0]  ramp_vel;
    logic [REM_W-1:0]    ramp_vr;

    assign vr_sum = DIV_IN_W'(vel_rem_reg) + DIV_IN_W'(goal_acc_reg);

    srmp_cdiv #(
        .DIVISOR   (TICK_RATE)
    ) u_vel_div (
        .dividend  (vr_sum),
        .quotient  (dv_q),
        .remainder (vr_rem)
    );

    always_comb begin
        vel1_w = 19'(tick_vel);
        gv1_w  = 19'(tick_gv);
        dv_w   = $signed({2'b00, dv_q});
        n_up   = vel1_w + dv_w;
        n_dn   = vel1_w - dv_w;
        if (!has_acc) begin
            ramp_vel = tick_gv;
            ramp_vr  = '0;
        end else begin
            ramp_vr = vr_rem;
            if (vel1_w < gv1_w) begin
                ramp_vel = (n_up < gv1_w) ? 16'(n_up) : tick_gv;
            end else if (vel1_w > gv1_w) begin
                ramp_vel = (n_dn > gv1_w) ? 16'(n_dn) : tick_gv;
            end else begin
                ramp_vel = tick_vel;
            end
        end
    end

    // Position accumulator: one step whenever the accumulated velocity
    // reaches a whole tick period, truncating toward zero.
    logic signed [17:0]    ps_sum;
    logic [DIV_IN_W-1:0]   ps_mag, dx_q;
    logic [REM_W-1:0]      ps_rem;
    logic signed [REM_W:0] ramp_pr;
    logic                  step_any;
    logic signed [16:0]    av_abs, at_abs;
    logic signed [31:0]    ramp_pos, ramp_brake;
    logic signed [1:0]     ramp_step;

    always_comb begin
        ps_sum = 18'(pos_rem_reg) + 18'(ramp_vel);
        ps_mag = (ps_sum < 0) ? DIV_IN_W'(-ps_sum) : DIV_IN_W'(ps_sum);
    end

    srmp_cdiv #(
        .DIVISOR   (TICK_RATE)
    ) u_pos_div (
        .dividend  (ps_mag),
        .quotient  (dx_q),
        .remainder (ps_rem)
    );

    always_comb begin
        ramp_pr    = (ps_sum < 0) ? -$signed({1'b0, ps_rem}) : $signed({1'b0, ps_rem});
        step_any   = dx_q != '0;
        av_abs     = (ramp_vel < 0) ? -17'(ramp_vel) : 17'(ramp_vel);
        at_abs     = (tick_gv < 0) ? -17'(tick_gv) : 17'(tick_gv);
        ramp_pos   = now_pos_reg;
        ramp_brake = brake_reg;
        ramp_step  = STEP_NONE;
        if (step_any) begin
            ramp_step = (ps_sum < 0) ? STEP_REV : STEP_FWD;
            ramp_pos  = (ps_sum < 0) ? now_pos_reg - 32'sd1 : now_pos_reg + 32'sd1;
            if (tick_vel != tick_gv) begin
                ramp_brake = (av_abs < at_abs) ? brake_reg + 32'sd1 : brake_reg - 32'sd1;
            end
        end
    end

    // Request decode and next state.
    logic signed [16:0] req_vel_abs;

    always_comb begin
        mode_next     = mode_reg;
        goal_pos_next = goal_pos_reg;
        goal_vel_next = goal_vel_reg;
        goal_acc_next = goal_acc_reg;
        now_pos_next  = now_pos_reg;
        now_vel_next  = now_vel_reg;
        vel_rem_next  = vel_rem_reg;
        pos_rem_next  = pos_rem_reg;
        brake_next    = brake_reg;
        pulse_next    = pulse_reg;
        accepted_next = 1'b1;
        step_next     = STEP_NONE;
        req_vel_abs   = (vel_reg < 0) ? -17'(vel_reg) : 17'(vel_reg);
        case (op_t'(op_reg))
            OP_TICK: begin
                mode_next     = tick_mode;
                goal_vel_next = tick_gv;
                pulse_next    = tick_pulse;
                now_vel_next  = ramp_vel;
                vel_rem_next  = ramp_vr;
                pos_rem_next  = ramp_pr;
                now_pos_next  = ramp_pos;
                brake_next    = ramp_brake;
                step_next     = ramp_step;
            end
            OP_SET_TARGET: begin
                if (req_vel_abs <= 17'(SPEED_LIMIT) && pos_reg >= 0
                        && pos_reg <= 32'(POSITION_LIMIT)) begin
                    goal_pos_next = pos_reg;
                    goal_vel_next = vel_reg;
                    goal_acc_next = acc_reg;
                end else begin
                    accepted_next = 1'b0;
                end
            end
            OP_SET_CURRENT: begin
                now_pos_next = pos_reg;
                now_vel_next = vel_reg;
            end
            default: begin
                accepted_next = 1'b1;
            end
        endcase
    end

    logic [1:0]         mstate_next;
    logic [15:0]        rate_next;

    always_comb begin
        case (mode_next)
            MODE_IDLE:     mstate_next = MSTATE_IDLE;
            MODE_MOVING:   mstate_next = MSTATE_MOVING;
            MODE_STOPPING: mstate_next = MSTATE_STOPPING;
            default:       mstate_next = MSTATE_IDLE;
        endcase
        rate_next = (now_vel_next < 0) ? 16'(-17'(now_vel_next)) : 16'(now_vel_next);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= MODE_IDLE;
            goal_pos_reg <= '0;
            goal_vel_reg <= '0;
            goal_acc_reg <= '0;
            now_pos_reg  <= '0;
            now_vel_reg  <= '0;
            vel_rem_reg  <= '0;
            pos_rem_reg  <= '0;
            brake_reg    <= '0;
            pulse_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (fire) begin
                m_valid_reg  <= 1'b1;
                mode_reg     <= mode_next;
                goal_pos_reg <= goal_pos_next;
                goal_vel_reg <= goal_vel_next;
                goal_acc_reg <= goal_acc_next;
                now_pos_reg  <= now_pos_next;
                now_vel_reg  <= now_vel_next;
                vel_rem_reg  <= vel_rem_next;
                pos_rem_reg  <= pos_rem_next;
                brake_reg    <= brake_next;
                pulse_reg    <= pulse_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg  <= s_operation;
            pos_reg <= s_position;
            vel_reg <= s_velocity;
            acc_reg <= s_acceleration;
        end
        if (fire) begin
            acc_ok_reg <= accepted_next;
            mstate_reg <= mstate_next;
            fwd_reg    <= now_vel_next > 0;
            rate_reg   <= rate_next;
            pwm_reg    <= pulse_next;
            step_reg   <= step_next;
            rpos_reg   <= now_pos_next;
            rvel_reg   <= now_vel_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = acc_ok_reg;
    assign m_motion_state  = mstate_reg;
    assign m_forward       = fwd_reg;
    assign m_step_rate     = rate_reg;
    assign m_pwm_on        = pwm_reg;
    assign m_step_taken    = step_reg;
    assign m_ramp_position = rpos_reg;
    assign m_ramp_velocity = rvel_reg;

endmodule
